/* rtl/flcu_pkg.sv */
// Package for the fully associative LRU cache unit.
// Holds field widths, command and state codes, and the cell control/status structs.
// No dependencies; used by flcu_cell and fully_assoc_lru_cache_unit.
package flcu_pkg;

  localparam int unsigned LinesDefault = 16;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned TagW         = 30;
  localparam int unsigned DataW        = 32;
  localparam int unsigned UsedW        = 4;
  localparam int unsigned InTdataW     = 104;
  localparam int unsigned OutTdataW    = 40;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_e;

  // Control from the top level to every cell.
  typedef struct packed {
    logic cmp_en;  // capture the tag compare for the accepted transaction
    logic shift;   // load the entry offered by the neighbor (the new head for cell 0)
  } cell_ctrl_t;

  // Status from a cell back to the top level.
  typedef struct packed {
    logic valid;
    logic match;
  } cell_stat_t;

endpackage

/* rtl/flcu_cell.sv */
// One cell of the recency chain: a cache line with its line number, tag and data.
// Depends on flcu_pkg. Instantiated in a row by fully_assoc_lru_cache_unit.
module flcu_cell #(
  parameter int unsigned IdxW = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  flcu_pkg::cell_ctrl_t     ctrl_i,
  input  logic [flcu_pkg::TagW-1:0]  look_tag_i,
  input  logic                     prev_valid_i,
  input  logic [IdxW-1:0]          prev_idx_i,
  input  logic [flcu_pkg::TagW-1:0]  prev_tag_i,
  input  logic [flcu_pkg::DataW-1:0] prev_data_i,
  output flcu_pkg::cell_stat_t     stat_o,
  output logic [IdxW-1:0]          idx_o,
  output logic [flcu_pkg::TagW-1:0]  tag_o,
  output logic [flcu_pkg::DataW-1:0] data_o
);

  logic                       valid_q;
  logic                       match_q, match_d;
  logic [IdxW-1:0]            idx_q;
  logic [flcu_pkg::TagW-1:0]  tag_q;
  logic [flcu_pkg::DataW-1:0] data_q;

  assign match_d = valid_q && (tag_q == look_tag_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.cmp_en) begin
        match_q <= match_d;
      end
      if (ctrl_i.shift) begin
        valid_q <= prev_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      idx_q  <= prev_idx_i;
      tag_q  <= prev_tag_i;
      data_q <= prev_data_i;
    end
  end

  assign stat_o.valid = valid_q;
  assign stat_o.match = match_q;
  assign idx_o        = idx_q;
  assign tag_o        = tag_q;
  assign data_o       = data_q;

endmodule

/* rtl/fully_assoc_lru_cache_unit.sv */
// Each transaction has an accept cycle and an update cycle: in the accept cycle each cell
// compares its tag with the incoming address and registers the result; in the update cycle
// the recency chain shifts and the result register is loaded. A new transaction is accepted
// in the cycle after that shift, since its lookup sees the updated chain; the accept
// cycle can overlap a result still waiting on the output. The update cycle is held while
// the output register is full and not taken. Lines sit in recency order, cell 0 most
// recent and the last cell the replacement victim once all lines are in use.
//
// Top level of the fully associative cache unit with LRU replacement and write-through.
// Depends on flcu_pkg and flcu_cell.
module fully_assoc_lru_cache_unit #(
  parameter int unsigned Lines = flcu_pkg::LinesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] command, [32:1] address, [64:33] write_data, [96:65] fill_data, rest zero
  input  logic [flcu_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] read_data, [32] hit, [36:33] line_used, [37] evicted, [38] memory_write,
  // [39] zero
  output logic [flcu_pkg::OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(Lines);
  localparam int unsigned CntW = $clog2(Lines + 1);
  localparam int unsigned TagW = flcu_pkg::TagW;
  localparam int unsigned DataW = flcu_pkg::DataW;
  localparam int unsigned UsedW = flcu_pkg::UsedW;

  flcu_pkg::state_e state_q, state_d;
  flcu_pkg::cmd_e   cmd_q;
  logic [TagW-1:0]  tag_q;
  logic [DataW-1:0] wdata_q;
  logic [DataW-1:0] fdata_q;
  logic [CntW-1:0]  filled_q;

  logic m_valid_q;
  logic [flcu_pkg::OutTdataW-1:0] m_data_q, m_data_d;

  logic accept;
  logic out_free;
  logic do_update;
  logic apply;
  logic is_write;
  logic hit;
  logic full;
  logic [TagW-1:0] in_tag;

  logic [Lines-1:0] c_valid;
  logic [Lines-1:0] c_match;
  logic [Lines-1:0] at_or_below;
  logic [Lines-1:0] shift;
  logic [IdxW-1:0]  c_idx  [Lines];
  logic [TagW-1:0]  c_tag  [Lines];
  logic [DataW-1:0] c_data [Lines];
  logic [IdxW-1:0]  p_idx  [Lines];
  logic [TagW-1:0]  p_tag  [Lines];
  logic [DataW-1:0] p_data [Lines];
  logic [Lines-1:0] p_valid;

  logic [IdxW-1:0]  hit_idx;
  logic [DataW-1:0] hit_data;
  logic [IdxW-1:0]  head_idx;
  logic [DataW-1:0] head_data;
  logic [DataW-1:0] rdata;
  logic [IdxW-1:0]  used_idx;
  logic [IdxW+UsedW-1:0] used_wide;
  logic evicted;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_tag   = s_axis_tdata[32:3];
  assign out_free = !m_valid_q || m_axis_tready;
  assign do_update = (state_q == flcu_pkg::ST_UPDATE) && out_free;
  assign is_write = (cmd_q == flcu_pkg::CMD_WRITE);
  assign hit      = |c_match;
  assign full     = c_valid[Lines-1];
  assign apply    = do_update && (hit || !is_write);

  assign s_axis_tready = (state_q == flcu_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      flcu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = flcu_pkg::ST_UPDATE;
        end
      end
      flcu_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_d = flcu_pkg::ST_IDLE;
        end
      end
      default: state_d = flcu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= flcu_pkg::ST_IDLE;
      filled_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_update && !is_write && !hit && !full) begin
        filled_q <= filled_q + CntW'(1);
      end
      if (do_update) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= flcu_pkg::cmd_e'(s_axis_tdata[0]);
      tag_q   <= in_tag;
      wdata_q <= s_axis_tdata[64:33];
      fdata_q <= s_axis_tdata[96:65];
    end
    if (do_update) begin
      m_data_q <= m_data_d;
    end
  end

  // Tags are unique among valid lines, so at most one match bit is set and an
  // AND-OR reduction selects the hit line.
  always_comb begin
    hit_idx  = '0;
    hit_data = '0;
    for (int k = 0; k < Lines; k++) begin
      hit_idx  = hit_idx  | (c_idx[k]  & {IdxW{c_match[k]}});
      hit_data = hit_data | (c_data[k] & {DataW{c_match[k]}});
    end
  end

  // New head of the chain: the touched line, the filled line or the replacement.
  always_comb begin
    if (hit) begin
      head_idx = hit_idx;
    end else if (full) begin
      head_idx = c_idx[Lines-1];
    end else begin
      head_idx = filled_q[IdxW-1:0];
    end
    if (is_write) begin
      head_data = wdata_q;
    end else if (hit) begin
      head_data = hit_data;
    end else begin
      head_data = fdata_q;
    end
  end

  always_comb begin
    rdata     = is_write ? '0 : head_data;
    used_idx  = (is_write && !hit) ? '0 : head_idx;
    used_wide = {{UsedW{1'b0}}, used_idx};
    evicted   = !is_write && !hit && full;
    m_data_d  = '0;
    m_data_d[31:0]  = rdata;
    m_data_d[32]    = hit;
    m_data_d[36:33] = used_wide[UsedW-1:0];
    m_data_d[37]    = evicted;
    m_data_d[38]    = is_write;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  for (genvar k = 0; k < Lines; k++) begin : g_cell
    flcu_pkg::cell_ctrl_t ctrl;
    flcu_pkg::cell_stat_t stat;

    // On a hit at position p, cells 1..p take their neighbor's line; on a read miss
    // the whole chain moves and the last line drops out.
    assign at_or_below[k] = |c_match[Lines-1:k];

    if (k == 0) begin : g_head
      assign shift[k]   = apply;
      assign p_valid[k] = 1'b1;
      assign p_idx[k]   = head_idx;
      assign p_tag[k]   = tag_q;
      assign p_data[k]  = head_data;
    end else begin : g_body
      assign shift[k]   = apply && (!hit || at_or_below[k]);
      assign p_valid[k] = c_valid[k-1];
      assign p_idx[k]   = c_idx[k-1];
      assign p_tag[k]   = c_tag[k-1];
      assign p_data[k]  = c_data[k-1];
    end

    assign ctrl.cmp_en = accept;
    assign ctrl.shift  = shift[k];

    flcu_cell #(
      .IdxW(IdxW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .look_tag_i  (in_tag),
      .prev_valid_i(p_valid[k]),
      .prev_idx_i  (p_idx[k]),
      .prev_tag_i  (p_tag[k]),
      .prev_data_i (p_data[k]),
      .stat_o      (stat),
      .idx_o       (c_idx[k]),
      .tag_o       (c_tag[k]),
      .data_o      (c_data[k])
    );

    assign c_valid[k] = stat.valid;
    assign c_match[k] = stat.match;
  end

  // A lookup never finds the same tag in two lines.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flcu_pkg::ST_UPDATE) |-> $onehot0(c_match))
    else $error("more than one line matched the lookup tag");

  // The number of valid lines tracks the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(c_valid) == filled_q)
    else $error("valid line count differs from fill count");

  // Valid lines stay packed at the recent end of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid & (c_valid + Lines'(1))) == '0)
    else $error("valid lines are not contiguous in the chain");

  // An accepted transaction always moves on to the update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == flcu_pkg::ST_UPDATE))
    else $error("accepted transaction did not reach the update cycle");

  // Only a read miss on a full cache replaces a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[37]) |-> (!m_data_q[38] && !m_data_q[32]))
    else $error("eviction reported for a write or a hit");

endmodule
